/* rtl/i2cras_pkg.sv */
// Types and constants shared by the I2C register access sequencer.
package i2cras_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EVENT = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TX   = 2'd1,
    PH_RX   = 2'd2,
    PH_ERR  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    RS_PROGRESS  = 3'd0,
    RS_DONE      = 3'd1,
    RS_USAGE     = 3'd2,
    RS_SW        = 3'd3,
    RS_ADDR_NACK = 3'd4,
    RS_DATA_NACK = 3'd5,
    RS_ARB       = 3'd6
  } result_e;

  typedef enum logic [2:0] {
    CMD_NONE           = 3'd0,
    CMD_RUN_START      = 3'd1,
    CMD_RUN_START_STOP = 3'd2,
    CMD_RUN_START_ACK  = 3'd3,
    CMD_RUN            = 3'd4,
    CMD_RUN_STOP       = 3'd5,
    CMD_RUN_ACK        = 3'd6,
    CMD_STOP           = 3'd7
  } cmd_e;

  localparam int CntW = 5;
  localparam logic [CntW-1:0] MaxReadLen = 5'd16;
  localparam logic [6:0] AllowedReset = 7'd90;

  localparam int EvDone = 0;
  localparam int EvStop = 1;
  localparam int EvErr  = 2;

  localparam int BsBusy     = 0;
  localparam int BsError    = 1;
  localparam int BsArb      = 2;
  localparam int BsAddrNack = 3;
  localparam int BsDataNack = 4;

  localparam int OutDepth = 4;
  localparam int OutPtrW  = 2;
  localparam int OutCntW  = 3;

  typedef struct packed {
    op_e             op;
    logic [6:0]      dev_addr;
    logic [7:0]      reg_addr;
    logic [7:0]      data_byte;
    logic [4:0]      read_len;
    logic [2:0]      events;
    logic [4:0]      bus_status;
  } in_item_t;

  typedef struct packed {
    cmd_e            cmd;
    logic            target_valid;
    logic [7:0]      target_byte;
    logic            tx_valid;
    logic [7:0]      tx_byte;
    logic            rx_valid;
    logic [7:0]      rx_byte;
    result_e         result;
    logic            idle;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic two;
  } push_t;

endpackage

/* rtl/i2cras_chan_if.sv */
// Valid/ready channel carrying one payload beat.
interface i2cras_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2cras_step.sv */
// Sequencer state and the per-item step logic producing up to two results.
module i2cras_step import i2cras_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   item_i,
  input  logic       commit_i,
  input  logic [6:0] allowed_i,
  output out_item_t  item0_o,
  output out_item_t  item1_o,
  output logic       two_o
);

  phase_e          phase_q, phase_d;
  result_e         status_q, status_d;
  logic [6:0]      target_q, target_d;
  logic            is_read_q, is_read_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      wbyte_q, wbyte_d;

  logic [CntW-1:0] len_c;
  logic [CntW:0]   idx_plus2;
  logic            usage;
  logic            err_hit;
  result_e         err_code;
  result_e         res;
  out_item_t       it0, it1;
  logic            two;

  assign len_c     = (item_i.read_len > MaxReadLen) ? MaxReadLen : item_i.read_len;
  assign idx_plus2 = {1'b0, idx_q} + (CntW+1)'(2);
  assign err_hit   = item_i.events[EvErr] && !item_i.bus_status[BsBusy] &&
                     (item_i.bus_status[BsError] || item_i.bus_status[BsArb]);

  always_comb begin
    err_code = RS_PROGRESS;
    if (item_i.bus_status[BsAddrNack]) err_code = RS_ADDR_NACK;
    if (item_i.bus_status[BsDataNack]) err_code = RS_DATA_NACK;
    if (item_i.bus_status[BsArb])      err_code = RS_ARB;
  end

  always_comb begin
    phase_d   = phase_q;
    status_d  = status_q;
    target_d  = target_q;
    is_read_d = is_read_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    wbyte_d   = wbyte_q;
    it0       = '0;
    it1       = '0;
    two       = 1'b0;
    usage     = 1'b0;
    unique case (item_i.op) inside
      OP_WRITE, OP_READ: begin
        if (item_i.dev_addr != allowed_i || phase_q != PH_IDLE) begin
          usage = 1'b1;
        end else begin
          target_d         = item_i.dev_addr;
          is_read_d        = (item_i.op == OP_READ);
          idx_d            = '0;
          cnt_d            = (item_i.op == OP_READ) ? len_c : CntW'(1);
          wbyte_d          = item_i.data_byte;
          status_d         = RS_PROGRESS;
          phase_d          = PH_TX;
          it0.cmd          = CMD_RUN_START;
          it0.target_valid = 1'b1;
          it0.target_byte  = {item_i.dev_addr, 1'b0};
          it0.tx_valid     = 1'b1;
          it0.tx_byte      = item_i.reg_addr;
        end
      end
      OP_EVENT: begin
        if (phase_q != PH_IDLE) begin
          if (item_i.events[EvDone]) begin
            if (phase_q == PH_TX && is_read_q) begin
              phase_d          = PH_RX;
              it0.target_valid = 1'b1;
              it0.target_byte  = {target_q, 1'b1};
              if (cnt_q == CntW'(1)) begin
                it0.cmd = CMD_RUN_START_STOP;
              end else if (cnt_q > CntW'(1)) begin
                it0.cmd = CMD_RUN_START_ACK;
              end else begin
                status_d = RS_SW;
                phase_d  = PH_ERR;
                it0.cmd  = CMD_STOP;
              end
            end else if (phase_q == PH_TX) begin
              if (idx_q == '0) begin
                it0.tx_valid = 1'b1;
                it0.tx_byte  = wbyte_q;
                it0.cmd      = CMD_RUN_STOP;
                idx_d        = CntW'(1);
              end
            end else if (phase_q == PH_RX) begin
              if (idx_plus2 < {1'b0, cnt_q}) begin
                it0.rx_valid = 1'b1;
                it0.rx_byte  = item_i.data_byte;
                it0.cmd      = CMD_RUN_ACK;
                idx_d        = idx_q + CntW'(1);
              end else if (idx_plus2 == {1'b0, cnt_q}) begin
                it0.rx_valid = 1'b1;
                it0.rx_byte  = item_i.data_byte;
                it0.cmd      = CMD_RUN_STOP;
                idx_d        = idx_q + CntW'(1);
              end
            end
          end
          if (item_i.events[EvStop]) begin
            if (phase_d == PH_RX) begin
              if (idx_d < cnt_q) begin
                if (it0.rx_valid) begin
                  two          = 1'b1;
                  it1.rx_valid = 1'b1;
                  it1.rx_byte  = item_i.data_byte;
                end else begin
                  it0.rx_valid = 1'b1;
                  it0.rx_byte  = item_i.data_byte;
                end
                idx_d = idx_d + CntW'(1);
              end
              status_d = RS_DONE;
            end else if (phase_d == PH_TX) begin
              status_d = RS_DONE;
            end
            phase_d = PH_IDLE;
          end
          if (err_hit) begin
            if (err_code != RS_PROGRESS) begin
              status_d = err_code;
              phase_d  = item_i.events[EvStop] ? PH_IDLE : PH_ERR;
            end
            if (!item_i.events[EvStop]) begin
              if (it0.cmd != CMD_NONE) begin
                two     = 1'b1;
                it1.cmd = CMD_STOP;
              end else begin
                it0.cmd = CMD_STOP;
              end
            end
          end
        end
      end
      OP_NONE: begin
      end
    endcase
    res        = usage ? RS_USAGE : status_d;
    it0.result = res;
    it1.result = res;
    it0.idle   = (phase_d == PH_IDLE);
    it1.idle   = (phase_d == PH_IDLE);
    it0.last   = !two;
    it1.last   = 1'b1;
  end

  assign item0_o = it0;
  assign item1_o = it1;
  assign two_o   = two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      status_q  <= RS_DONE;
      target_q  <= '0;
      is_read_q <= 1'b0;
      idx_q     <= '0;
      cnt_q     <= '0;
      wbyte_q   <= '0;
    end else if (commit_i) begin
      phase_q   <= phase_d;
      status_q  <= status_d;
      target_q  <= target_d;
      is_read_q <= is_read_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      wbyte_q   <= wbyte_d;
    end
  end

endmodule

/* rtl/i2cras_outq.sv */
// Result queue that takes one or two beats per cycle and gives out one per cycle while the consumer is ready.
module i2cras_outq import i2cras_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  out_item_t item0_i,
  input  out_item_t item1_i,
  input  logic      ready_i,
  output logic      space_o,
  output logic      valid_o,
  output out_item_t data_o
);

  out_item_t            mem_q [OutDepth];
  logic [OutPtrW-1:0]   wr_q, rd_q;
  logic [OutCntW-1:0]   cnt_q;
  logic [1:0]           push_n;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign space_o = (cnt_q <= OutCntW'(OutDepth - 2));
  assign push_n  = !push_i.valid ? 2'd0 : (push_i.two ? 2'd2 : 2'd1);

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= item0_i;
      if (push_i.two) begin
        mem_q[wr_q + OutPtrW'(1)] <= item1_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OutPtrW'(push_n);
      rd_q  <= rd_q + OutPtrW'(pop);
      cnt_q <= cnt_q + OutCntW'(push_n) - OutCntW'(pop);
    end
  end

endmodule

/* rtl/i2c_register_access_sequencer.sv */
// Top level: input register, device register, step logic and result queue.
// An accepted item is held in the input register and stepped once the result queue has room;
// its result beats are registered in the queue before the first one is offered.
// One item per cycle is taken while the result queue has room for two beats;
// an item with two results needs two output beats, so the output port sets the pace.
// Reset clears the sequencer state, empties the queue and sets allowed_device to 90.
module i2c_register_access_sequencer import i2cras_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cras_chan_if.sink   req_i,
  i2cras_chan_if.source rsp_o,
  i2cras_chan_if.sink   cfg_i
);

  logic       in_valid_q;
  in_item_t   in_q;
  logic [6:0] allowed_q;
  logic       space;
  logic       commit;
  out_item_t  item0, item1;
  logic       two;
  push_t      push;

  assign commit      = in_valid_q && space;
  assign req_i.ready = !in_valid_q || commit;
  assign cfg_i.ready = 1'b1;
  assign push.valid  = commit;
  assign push.two    = two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      allowed_q  <= AllowedReset;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (cfg_i.valid) begin
        allowed_q <= cfg_i.data[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (req_i.valid && req_i.ready) begin
      in_q <= req_i.data;
    end
  end

  i2cras_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (in_q),
    .commit_i  (commit),
    .allowed_i (allowed_q),
    .item0_o   (item0),
    .item1_o   (item1),
    .two_o     (two)
  );

  i2cras_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item0_i (item0),
    .item1_i (item1),
    .ready_i (rsp_o.ready),
    .space_o (space),
    .valid_o (rsp_o.valid),
    .data_o  (rsp_o.data)
  );

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !commit |=> in_valid_q && $stable(in_q))
    else $error("Stalled input item was lost or changed.");

  a_take_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> in_valid_q)
    else $error("Accepted input beat did not reach the input register.");

  a_pair_agrees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && two |-> item0.result == item1.result && item0.idle == item1.idle &&
                      !item0.last && item1.last)
    else $error("Two result beats of one item disagree.");

endmodule

/* tb/tb_i2c_register_access_sequencer.sv */
// Self-checking testbench for the I2C register access sequencer with a scoreboard.
`timescale 1ns / 1ps

module tb_i2c_register_access_sequencer;
  import i2cras_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 12;
  localparam int PhaseItems  = 540;

  localparam logic [2:0] MaskDone = 3'(1 << EvDone);
  localparam logic [2:0] MaskStop = 3'(1 << EvStop);
  localparam logic [2:0] MaskErr  = 3'(1 << EvErr);

  localparam logic [4:0] MaskBusy     = 5'(1 << BsBusy);
  localparam logic [4:0] MaskBusErr   = 5'(1 << BsError);
  localparam logic [4:0] MaskArb      = 5'(1 << BsArb);
  localparam logic [4:0] MaskAddrNack = 5'(1 << BsAddrNack);
  localparam logic [4:0] MaskDataNack = 5'(1 << BsDataNack);

  class access_scoreboard;
    out_item_t   pending_beats[$];
    int          errors;
    int          beats_seen;
    logic [6:0]  allowed_dev;
    phase_e      phase;
    result_e     status;
    logic [6:0]  target;
    logic        reading;
    logic [4:0]  byte_idx;
    logic [4:0]  byte_cnt;
    logic [7:0]  wr_byte;

    function new();
      errors      = 0;
      beats_seen  = 0;
      allowed_dev = AllowedReset;
      phase       = PH_IDLE;
      status      = RS_DONE;
      target      = '0;
      reading     = 1'b0;
      byte_idx    = '0;
      byte_cnt    = '0;
      wr_byte     = '0;
    endfunction

    function void set_device(logic [6:0] value);
      allowed_dev = value;
    endfunction

    // Steps the sequencer model and queues its result beats; returns whether the item did work.
    function bit note_request(in_item_t item);
      out_item_t beat[2];
      int        n;
      int        lim;
      bit        refused;
      bit        useful;
      result_e   code;
      beat[0] = '0;
      beat[1] = '0;
      n       = 1;
      refused = 1'b0;
      useful  = (item.op != OP_NONE) && !(item.op == OP_EVENT && phase == PH_IDLE);
      if (item.op == OP_WRITE || item.op == OP_READ) begin
        if (item.dev_addr != allowed_dev || phase != PH_IDLE) begin
          refused = 1'b1;
        end else begin
          target   = item.dev_addr;
          reading  = (item.op == OP_READ);
          byte_idx = '0;
          if (!reading) byte_cnt = 5'd1;
          else if (item.read_len > MaxReadLen) byte_cnt = MaxReadLen;
          else byte_cnt = item.read_len;
          wr_byte  = item.data_byte;
          status   = RS_PROGRESS;
          phase    = PH_TX;
          beat[0].cmd          = CMD_RUN_START;
          beat[0].target_valid = 1'b1;
          beat[0].target_byte  = {item.dev_addr, 1'b0};
          beat[0].tx_valid     = 1'b1;
          beat[0].tx_byte      = item.reg_addr;
        end
      end else if (item.op == OP_EVENT && phase != PH_IDLE) begin
        if (item.events[EvDone]) begin
          if (phase == PH_TX && reading) begin
            phase = PH_RX;
            beat[0].target_valid = 1'b1;
            beat[0].target_byte  = {target, 1'b1};
            if (byte_cnt == 5'd1) begin
              beat[0].cmd = CMD_RUN_START_STOP;
            end else if (byte_cnt > 5'd1) begin
              beat[0].cmd = CMD_RUN_START_ACK;
            end else begin
              status      = RS_SW;
              phase       = PH_ERR;
              beat[0].cmd = CMD_STOP;
            end
          end else if (phase == PH_TX) begin
            if (byte_idx == '0) begin
              beat[0].tx_valid = 1'b1;
              beat[0].tx_byte  = wr_byte;
              beat[0].cmd      = CMD_RUN_STOP;
              byte_idx         = 5'd1;
            end
          end else if (phase == PH_RX) begin
            lim = int'(byte_cnt) - 2;
            if (int'(byte_idx) < lim) begin
              beat[0].rx_valid = 1'b1;
              beat[0].rx_byte  = item.data_byte;
              beat[0].cmd      = CMD_RUN_ACK;
              byte_idx         = byte_idx + 5'd1;
            end else if (int'(byte_idx) == lim) begin
              beat[0].rx_valid = 1'b1;
              beat[0].rx_byte  = item.data_byte;
              beat[0].cmd      = CMD_RUN_STOP;
              byte_idx         = byte_idx + 5'd1;
            end
          end
        end
        if (item.events[EvStop]) begin
          if (phase == PH_RX) begin
            if (byte_idx < byte_cnt) begin
              if (beat[0].rx_valid) n = 2;
              beat[n-1].rx_valid = 1'b1;
              beat[n-1].rx_byte  = item.data_byte;
              byte_idx           = byte_idx + 5'd1;
            end
            status = RS_DONE;
          end else if (phase == PH_TX) begin
            status = RS_DONE;
          end
          phase = PH_IDLE;
        end
        if (item.events[EvErr] && !item.bus_status[BsBusy] &&
            (item.bus_status[BsError] || item.bus_status[BsArb])) begin
          code = RS_PROGRESS;
          if (item.bus_status[BsAddrNack]) code = RS_ADDR_NACK;
          if (item.bus_status[BsDataNack]) code = RS_DATA_NACK;
          if (item.bus_status[BsArb]) code = RS_ARB;
          if (code != RS_PROGRESS) begin
            status = code;
            if (item.events[EvStop]) phase = PH_IDLE;
            else phase = PH_ERR;
          end
          if (!item.events[EvStop]) begin
            if (beat[n-1].cmd != CMD_NONE) n++;
            beat[n-1].cmd = CMD_STOP;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        if (refused) beat[k].result = RS_USAGE;
        else beat[k].result = status;
        beat[k].idle = (phase == PH_IDLE);
        beat[k].last = (k == n - 1);
        pending_beats.push_back(beat[k]);
      end
      return useful;
    endfunction

    task report(string msg);
      $display("mismatch on beat %0d: %s", beats_seen, msg);
      errors++;
    endtask

    task check_response(out_item_t got);
      out_item_t want;
      beats_seen++;
      if (pending_beats.size() == 0) begin
        report($sformatf("beat %h arrived with nothing expected", got));
      end else begin
        want = pending_beats.pop_front();
        if (got.cmd !== want.cmd)
          report($sformatf("cmd %0d, expected %0d", got.cmd, want.cmd));
        if (got.target_valid !== want.target_valid)
          report($sformatf("target_valid %0b, expected %0b", got.target_valid,
                           want.target_valid));
        if (got.target_byte !== want.target_byte)
          report($sformatf("target_byte %h, expected %h", got.target_byte, want.target_byte));
        if (got.tx_valid !== want.tx_valid)
          report($sformatf("tx_valid %0b, expected %0b", got.tx_valid, want.tx_valid));
        if (got.tx_byte !== want.tx_byte)
          report($sformatf("tx_byte %h, expected %h", got.tx_byte, want.tx_byte));
        if (got.rx_valid !== want.rx_valid)
          report($sformatf("rx_valid %0b, expected %0b", got.rx_valid, want.rx_valid));
        if (got.rx_byte !== want.rx_byte)
          report($sformatf("rx_byte %h, expected %h", got.rx_byte, want.rx_byte));
        if (got.result !== want.result)
          report($sformatf("result %0d, expected %0d", got.result, want.result));
        if (got.idle !== want.idle)
          report($sformatf("idle %0b, expected %0b", got.idle, want.idle));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic hold_rsp;
  int   src_gap;
  int   sink_gap;
  int   items_sent;
  int   cycles;

  access_scoreboard sb;

  i2cras_chan_if #(.T(in_item_t))   req_if ();
  i2cras_chan_if #(.T(out_item_t))  rsp_if ();
  i2cras_chan_if #(.T(logic [6:0])) cfg_if ();

  i2c_register_access_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= !hold_rsp && ($urandom_range(0, 99) >= sink_gap);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t mk(op_e op, logic [6:0] dev, logic [7:0] rg, logic [7:0] data,
                                  logic [4:0] len, logic [2:0] ev, logic [4:0] bs);
    in_item_t item;
    item.op         = op;
    item.dev_addr   = dev;
    item.reg_addr   = rg;
    item.data_byte  = data;
    item.read_len   = len;
    item.events     = ev;
    item.bus_status = bs;
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < src_gap) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (sb.note_request(item)) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending_beats.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_device(input logic [6:0] value);
    req_if.valid <= 1'b0;
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.set_device(value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_directed();
    logic [6:0] dev;
    dev = AllowedReset;
    send_item(mk(OP_WRITE, dev + 7'd1, 8'h12, 8'h34, 5'd1, '0, '0));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskDone, '0));
    send_item(mk(OP_NONE, 7'h7f, 8'hff, 8'hff, 5'h1f, 3'h7, 5'h1f));
    send_item(mk(OP_WRITE, dev, 8'hff, 8'h00, 5'd0, '0, '0));
    send_item(mk(OP_READ, dev, 8'h01, 8'h02, 5'd4, '0, '0));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskDone, '0));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskStop, '0));
    send_item(mk(OP_READ, dev, 8'h00, 8'hff, 5'd31, '0, '0));
    send_item(mk(OP_EVENT, '0, '0, 8'h00, '0, MaskDone, '0));
    send_item(mk(OP_EVENT, '0, '0, 8'hff, '0, MaskDone, '0));
    send_item(mk(OP_EVENT, '0, '0, 8'h5a, '0, MaskDone | MaskErr,
                 MaskBusErr | MaskArb | MaskAddrNack | MaskDataNack));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskStop, '0));
    send_item(mk(OP_READ, dev, 8'h10, 8'h00, 5'd0, '0, '0));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskDone, '0));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskStop | MaskErr, MaskBusErr));
    send_item(mk(OP_READ, dev, 8'h20, 8'h00, 5'd2, '0, '0));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskDone, '0));
    send_item(mk(OP_EVENT, '0, '0, 8'haa, '0, MaskDone | MaskStop, '0));
    send_item(mk(OP_WRITE, dev, 8'h30, 8'h55, 5'd1, '0, '0));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskErr, MaskBusy | MaskBusErr));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskDone, '0));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskErr | MaskStop, MaskBusErr | MaskAddrNack));
    send_item(mk(OP_WRITE, dev, 8'h40, 8'h66, 5'd1, '0, '0));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskDone | MaskErr, MaskArb | MaskDataNack));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskErr, MaskBusErr));
    send_item(mk(OP_EVENT, '0, '0, '0, '0, MaskStop, '0));
  endtask

  task automatic run_transfer();
    in_item_t   item;
    int         sel;
    int         len;
    int         n_ev;
    logic [2:0] ev;
    item = random_item();
    if ($urandom_range(0, 1)) item.op = OP_READ;
    else item.op = OP_WRITE;
    if ($urandom_range(0, 99) < 95) item.dev_addr = sb.allowed_dev;
    sel = $urandom_range(0, 99);
    if (sel < 80) item.read_len = 5'($urandom_range(1, 16));
    else if (sel < 90) item.read_len = 5'($urandom_range(17, 31));
    else item.read_len = '0;
    send_item(item);
    len = (item.read_len > MaxReadLen) ? int'(MaxReadLen) : int'(item.read_len);
    if (item.op == OP_READ) n_ev = ((len == 0) ? 1 : len) + 1;
    else n_ev = 2 + int'($urandom_range(0, 9) == 0);
    for (int i = 0; i < n_ev; i++) begin
      ev = '0;
      if (i == n_ev - 1) begin
        ev[EvStop] = 1'b1;
        ev[EvDone] = ($urandom_range(0, 9) == 0);
      end else begin
        ev[EvDone] = 1'b1;
      end
      ev[EvErr] = ($urandom_range(0, 99) < 5);
      item = random_item();
      item.op = OP_EVENT;
      item.events = ev;
      send_item(item);
    end
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 99) < 75) run_transfer();
      else send_item(random_item());
    end
  endtask

  initial begin
    sb           = new();
    items_sent   = 0;
    cycles       = 0;
    hold_rsp     = 1'b0;
    src_gap      = 17;
    sink_gap     = 45;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();

    src_gap  = 17;
    sink_gap = 45;
    set_device(7'd0);
    run_random(PhaseItems);

    src_gap  = 45;
    sink_gap = 17;
    set_device(7'd127);
    run_random(PhaseItems);

    src_gap  = 0;
    sink_gap = 0;
    set_device(7'($urandom_range(1, 126)));
    fork
      begin
        hold_rsp <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_rsp <= 1'b0;
      end
    join_none
    run_random(PhaseItems);

    req_if.valid <= 1'b0;
    wait_drained();
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
